@@ hdl/acm_pkg.sv @@
package acm_pkg;

    localparam int KEY_WORDS_MAX = 60;
    localparam int RK_AW = 6;

    localparam logic [2:0] CFG_KEY_A   = 3'd0;
    localparam logic [2:0] CFG_KEY_B   = 3'd1;
    localparam logic [2:0] CFG_KEY_C   = 3'd2;
    localparam logic [2:0] CFG_KEY_D   = 3'd3;
    localparam logic [2:0] CFG_KEY_LEN = 3'd4;
    localparam logic [2:0] CFG_TAG_LEN = 3'd5;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    localparam logic [7:0] DBL_POLY = 8'h87;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  valid_bytes;
        logic        last_block;
    } acm_in_t;

    typedef struct packed {
        logic [63:0] tag_high;
        logic [63:0] tag_low;
        logic [4:0]  tag_length;
        logic        status;
    } acm_out_t;

    typedef struct packed {
        logic expand;
        logic encrypt;
    } acm_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

endpackage

@@ hdl/acm_ram.sv @@
module acm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/acm_core.sv @@
module acm_core
    import acm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  acm_cmd_t       cmd,
    input  logic [255:0]   key,
    input  logic [1:0]     key_length,
    input  logic [127:0]   data,
    output logic [127:0]   result,
    output logic           done
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_EXP  = 2'd1;
    localparam logic [1:0] C_ENC  = 2'd2;
    localparam logic [2:0] PH_MIX = 3'd4;

    function automatic logic [7:0] gf2(input logic [7:0] a);
        gf2 = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s);
        logic [127:0] o;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                o[127 - 8*(i + 4*c) -: 8] = s[127 - 8*(i + 4*((c + i) % 4)) -: 8];
            end
        end
        shift_rows = o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3, all;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0  = s[127 - 32*c -: 8];
            a1  = s[119 - 32*c -: 8];
            a2  = s[111 - 32*c -: 8];
            a3  = s[103 - 32*c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            o[127 - 32*c -: 8] = a0 ^ all ^ gf2(a0 ^ a1);
            o[119 - 32*c -: 8] = a1 ^ all ^ gf2(a1 ^ a2);
            o[111 - 32*c -: 8] = a2 ^ all ^ gf2(a2 ^ a3);
            o[103 - 32*c -: 8] = a3 ^ all ^ gf2(a3 ^ a0);
        end
        mix_columns = o;
    endfunction

    logic [1:0]   state_reg, state_next;
    logic [5:0]   idx_reg, idx_next;
    logic [2:0]   kmod_reg, kmod_next;
    logic [7:0]   rc_reg, rc_next;
    logic [31:0]  win_reg [8];
    logic [31:0]  win_new;
    logic [3:0]   rnd_reg, rnd_next;
    logic [2:0]   ph_reg, ph_next;
    logic [127:0] st_reg, st_next;
    logic [95:0]  rkr_reg, rkr_next;
    logic         done_reg, done_next;

    logic [2:0]   nk_m1;
    logic [3:0]   nr;
    logic [5:0]   total_m1;
    logic         we;
    logic [31:0]  rdata;
    logic [31:0]  t;
    logic [127:0] rk;
    logic [127:0] mixed;

    always_comb
    begin
        case (key_length)
            KEY_128:
            begin
                nk_m1 = 3'd3;
                nr    = 4'd10;
            end
            KEY_192:
            begin
                nk_m1 = 3'd5;
                nr    = 4'd12;
            end
            default:
            begin
                nk_m1 = 3'd7;
                nr    = 4'd14;
            end
        endcase
        total_m1 = {nr, 2'b11};
    end

    // next round-key word from the sliding window of the last nk words
    always_comb
    begin
        t = win_reg[0];
        rc_next = rc_reg;
        if (kmod_reg == 3'd0)
        begin
            t = sub_word({t[23:0], t[31:24]}) ^ {rc_reg, 24'h0};
            rc_next = gf2(rc_reg);
        end
        else if (nk_m1 == 3'd7 && kmod_reg == 3'd4)
        begin
            t = sub_word(t);
        end
        if (idx_reg <= {3'b000, nk_m1})
        begin
            win_new = key[255 - 32*idx_reg[2:0] -: 32];
            rc_next = rc_reg;
        end
        else
        begin
            win_new = win_reg[nk_m1] ^ t;
        end
    end

    assign rk    = {rkr_reg, rdata};
    assign mixed = (rnd_reg == nr) ? shift_rows(st_reg) : mix_columns(shift_rows(st_reg));
    assign we    = (state_reg == C_EXP);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        kmod_next  = kmod_reg;
        rnd_next   = rnd_reg;
        ph_next    = ph_reg;
        st_next    = st_reg;
        rkr_next   = rkr_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.expand)
                begin
                    state_next = C_EXP;
                    idx_next   = '0;
                    kmod_next  = '0;
                end
                else if (cmd.encrypt)
                begin
                    state_next = C_ENC;
                    st_next    = data;
                    rnd_next   = '0;
                    ph_next    = '0;
                end
            end
            C_EXP:
            begin
                idx_next  = idx_reg + 6'd1;
                kmod_next = (kmod_reg == nk_m1) ? 3'd0 : kmod_reg + 3'd1;
                if (idx_reg == total_m1)
                begin
                    state_next = C_IDLE;
                    done_next  = 1'b1;
                end
            end
            C_ENC:
            begin
                if (ph_reg != PH_MIX)
                begin
                    // one word through the S-boxes per cycle
                    if (rnd_reg != 4'd0)
                    begin
                        st_next = {st_reg[95:0], sub_word(st_reg[127:96])};
                    end
                    if (ph_reg != 3'd0)
                    begin
                        rkr_next = {rkr_reg[63:0], rdata};
                    end
                    ph_next = ph_reg + 3'd1;
                end
                else
                begin
                    st_next  = ((rnd_reg == 4'd0) ? st_reg : mixed) ^ rk;
                    ph_next  = '0;
                    rnd_next = rnd_reg + 4'd1;
                    if (rnd_reg == nr)
                    begin
                        state_next = C_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            kmod_reg  <= '0;
            rnd_reg   <= '0;
            ph_reg    <= '0;
            rc_reg    <= 8'h01;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            kmod_reg  <= kmod_next;
            rnd_reg   <= rnd_next;
            ph_reg    <= ph_next;
            if (state_reg == C_IDLE)
            begin
                rc_reg <= 8'h01;
            end
            else if (state_reg == C_EXP)
            begin
                rc_reg <= rc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        rkr_reg <= rkr_next;
        if (state_reg == C_EXP)
        begin
            win_reg[0] <= win_new;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    acm_ram #(
        .WIDTH (32),
        .DEPTH (KEY_WORDS_MAX)
    ) u_rk_ram (
        .clk   (clk),
        .we    (we),
        .waddr (idx_reg),
        .wdata (win_new),
        .raddr ({rnd_reg, ph_reg[1:0]}),
        .rdata (rdata)
    );

    assign result = st_reg;
    assign done   = done_reg;

endmodule

@@ hdl/aes_cmac_tag.sv @@
// AES-CMAC tag engine, AES-128/192/256.
// blk channel: one message block per transfer (valid/stall). Full blocks
// chain; the last block (flag set) yields one tag transfer on the tag
// channel. A short non-last block, or an empty last block after earlier
// blocks, yields status 1 with zero tag and drops the message.
// cfg channel: register writes (valid/ready, always ready); the user must write
// only while idle, the block itself does not enforce it. Key words or key
// length writes force key expansion and subkey derivation before the next
// block: key expansion, then one encryption. In one encryption each round
// fetches the round key word by word from the round-key RAM while, after
// the first round, the state goes one 32-bit word per cycle through a
// four-byte S-box slice; then a single mix/add step follows.
// A block is taken only when the engine is idle; the tag sits in an output
// register, so the next block is taken while the receiver stalls. A new
// result waits until that register is free.
// Reset clears chain, subkeys and handshake state; tag_bytes resets to 16.
module aes_cmac_tag
    import acm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         blk_valid,
    output logic         blk_stall,
    input  acm_in_t      blk,
    output logic         tag_valid,
    input  logic         tag_stall,
    output acm_out_t     tag,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_KWAIT  = 3'd1;
    localparam logic [2:0] S_LWAIT  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_RUN    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [63:0]  key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic [1:0]   key_len_reg;
    logic [4:0]   tag_bytes_reg;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] k1_reg, k1_next, k2_reg, k2_next;
    logic         ready_reg, ready_next;
    logic         started_reg, started_next;
    acm_in_t      item_reg;
    logic [4:0]   vb_reg, tlen_reg;
    acm_out_t     res_reg, res_next;
    acm_out_t     out_reg;
    logic         out_valid_reg;

    acm_cmd_t     cmd;
    logic [127:0] enc_data;
    logic [127:0] result;
    logic         done;
    logic         accept;
    logic         err;
    logic [127:0] blk128, padded, masked, k1_new;
    logic [4:0]   vb_in, tlen_in;
    logic         out_load;

    assign cfg_ready = 1'b1;
    assign blk_stall = (state_reg != S_IDLE);
    assign accept    = blk_valid && !blk_stall;
    assign tag_valid = out_valid_reg;
    assign tag       = out_reg;

    assign vb_in   = (blk.valid_bytes > 5'd16) ? 5'd16 : blk.valid_bytes;
    assign tlen_in = (tag_bytes_reg == 5'd0) ? 5'd1 :
                     ((tag_bytes_reg > 5'd16) ? 5'd16 : tag_bytes_reg);

    assign blk128 = {item_reg.block_high, item_reg.block_low};
    assign err    = (!item_reg.last_block && vb_reg != 5'd16) ||
                    (item_reg.last_block && vb_reg == 5'd0 && started_reg);

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            if (5'(k) < vb_reg)
            begin
                padded[127 - 8*k -: 8] = blk128[127 - 8*k -: 8];
            end
            else if (5'(k) == vb_reg)
            begin
                padded[127 - 8*k -: 8] = PAD_BYTE;
            end
            else
            begin
                padded[127 - 8*k -: 8] = 8'h00;
            end
            masked[127 - 8*k -: 8] = (5'(k) < tlen_reg) ? result[127 - 8*k -: 8] : 8'h00;
        end
    end

    // doubling in GF(2^128)
    assign k1_new = {result[126:0], 1'b0} ^ {120'h0, (result[127] ? DBL_POLY : 8'h00)};

    always_comb
    begin
        state_next   = state_reg;
        chain_next   = chain_reg;
        k1_next      = k1_reg;
        k2_next      = k2_reg;
        ready_next   = ready_reg;
        started_next = started_reg;
        res_next     = res_reg;
        cmd          = '0;
        enc_data     = '0;
        out_load     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!ready_reg)
                    begin
                        cmd.expand = 1'b1;
                        state_next = S_KWAIT;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_KWAIT:
            begin
                if (done)
                begin
                    cmd.encrypt = 1'b1;
                    state_next  = S_LWAIT;
                end
            end
            S_LWAIT:
            begin
                if (done)
                begin
                    k1_next    = k1_new;
                    k2_next    = {k1_new[126:0], 1'b0} ^
                                 {120'h0, (k1_new[127] ? DBL_POLY : 8'h00)};
                    ready_next = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (err)
                begin
                    chain_next   = '0;
                    started_next = 1'b0;
                    res_next     = '{tag_high: 64'h0, tag_low: 64'h0,
                                     tag_length: tlen_reg, status: 1'b1};
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.encrypt = 1'b1;
                    if (!item_reg.last_block)
                    begin
                        enc_data = chain_reg ^ blk128;
                    end
                    else if (vb_reg == 5'd16)
                    begin
                        enc_data = chain_reg ^ blk128 ^ k1_reg;
                    end
                    else
                    begin
                        enc_data = chain_reg ^ padded ^ k2_reg;
                    end
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (done)
                begin
                    if (!item_reg.last_block)
                    begin
                        chain_next   = result;
                        started_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        chain_next   = '0;
                        started_next = 1'b0;
                        res_next     = '{tag_high: masked[127:64], tag_low: masked[63:0],
                                         tag_length: tlen_reg, status: 1'b0};
                        state_next   = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !tag_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_valid && cfg_addr <= CFG_KEY_LEN)
        begin
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_a_reg     <= '0;
            key_b_reg     <= '0;
            key_c_reg     <= '0;
            key_d_reg     <= '0;
            key_len_reg   <= '0;
            tag_bytes_reg <= 5'd16;
            chain_reg     <= '0;
            k1_reg        <= '0;
            k2_reg        <= '0;
            ready_reg     <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chain_reg   <= chain_next;
            k1_reg      <= k1_next;
            k2_reg      <= k2_next;
            ready_reg   <= ready_next;
            started_reg <= started_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!tag_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_addr)
                    CFG_KEY_A:   key_a_reg     <= cfg_wdata;
                    CFG_KEY_B:   key_b_reg     <= cfg_wdata;
                    CFG_KEY_C:   key_c_reg     <= cfg_wdata;
                    CFG_KEY_D:   key_d_reg     <= cfg_wdata;
                    CFG_KEY_LEN: key_len_reg   <= cfg_wdata[1:0];
                    CFG_TAG_LEN: tag_bytes_reg <= cfg_wdata[4:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            item_reg <= blk;
            vb_reg   <= vb_in;
            tlen_reg <= tlen_in;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    acm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key        ({key_a_reg, key_b_reg, key_c_reg, key_d_reg}),
        .key_length (key_len_reg),
        .data       (enc_data),
        .result     (result),
        .done       (done)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import acm_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  SETTLE      = 250;
    localparam longint CYCLE_LIMIT = 3000000;

    // Golden CMAC model plus the queue of tags still owed by the block
    class cmac_scoreboard;
        logic [63:0]  key_word [4];
        logic [1:0]   key_len;
        logic [4:0]   tag_cfg;
        logic [127:0] chain;
        logic [127:0] k1;
        logic [127:0] k2;
        logic         subkeys_ok;
        logic         in_message;
        logic [31:0]  rk [60];
        acm_out_t     pending_tags [$];
        int           mismatches;
        int           tags_checked;
        int           errors_seen;

        function new();
            foreach (key_word[i]) key_word[i] = '0;
            key_len    = KEY_128;
            tag_cfg    = 5'd16;
            chain      = '0;
            k1         = '0;
            k2         = '0;
            subkeys_ok = 1'b0;
            in_message = 1'b0;
            mismatches = 0;
            tags_checked = 0;
            errors_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                CFG_KEY_A:   begin key_word[0] = val; subkeys_ok = 1'b0; end
                CFG_KEY_B:   begin key_word[1] = val; subkeys_ok = 1'b0; end
                CFG_KEY_C:   begin key_word[2] = val; subkeys_ok = 1'b0; end
                CFG_KEY_D:   begin key_word[3] = val; subkeys_ok = 1'b0; end
                CFG_KEY_LEN: begin key_len = val[1:0]; subkeys_ok = 1'b0; end
                CFG_TAG_LEN: tag_cfg = val[4:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] xtime(logic [7:0] a);
            return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        endfunction

        function int rounds();
            return (key_len == KEY_128) ? 10 : ((key_len == KEY_192) ? 12 : 14);
        endfunction

        function void expand();
            int nk;
            int total;
            logic [255:0] kw;
            logic [7:0] rcon;
            logic [31:0] t;
            nk = (key_len == KEY_128) ? 4 : ((key_len == KEY_192) ? 6 : 8);
            total = 4 * (rounds() + 1);
            kw = {key_word[0], key_word[1], key_word[2], key_word[3]};
            rcon = 8'h01;
            for (int i = 0; i < nk; i++)
                rk[i] = kw[255 - 32 * i -: 32];
            for (int i = nk; i < total; i++)
            begin
                t = rk[i - 1];
                if (i % nk == 0)
                begin
                    t = {t[23:0], t[31:24]};
                    t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
                    t = t ^ {rcon, 24'h0};
                    rcon = xtime(rcon);
                end
                else if (nk > 6 && i % nk == 4)
                    t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
                rk[i] = rk[i - nk] ^ t;
            end
        endfunction

        function logic [127:0] encrypt(logic [127:0] din);
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] a0, a1, a2, a3, all;
            logic [31:0] w;
            int nr;
            nr = rounds();
            for (int i = 0; i < 16; i++)
                s[i] = din[127 - 8 * i -: 8];
            for (int r = 0; r <= nr; r++)
            begin
                if (r > 0)
                begin
                    for (int i = 0; i < 16; i++)
                        t[i] = SBOX[s[i]];
                    for (int c = 0; c < 4; c++)
                        for (int i = 0; i < 4; i++)
                            s[i + 4 * c] = t[i + 4 * ((c + i) & 3)];
                    if (r != nr)
                        for (int c = 0; c < 4; c++)
                        begin
                            a0 = s[4 * c]; a1 = s[4 * c + 1];
                            a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                            all = a0 ^ a1 ^ a2 ^ a3;
                            s[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
                            s[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                            s[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                            s[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
                        end
                end
                for (int c = 0; c < 4; c++)
                begin
                    w = rk[4 * r + c];
                    for (int j = 0; j < 4; j++)
                        s[4 * c + j] ^= w[31 - 8 * j -: 8];
                end
            end
            for (int i = 0; i < 16; i++)
                din[127 - 8 * i -: 8] = s[i];
            return din;
        endfunction

        function logic [127:0] dbl(logic [127:0] v);
            return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
        endfunction

        function void note_block(acm_in_t b);
            int nbytes;
            int tlen;
            logic [127:0] msg;
            logic [127:0] res;
            acm_out_t exp_tag;
            nbytes = (b.valid_bytes > 16) ? 16 : b.valid_bytes;
            tlen = tag_cfg;
            if (tlen == 0) tlen = 1;
            if (tlen > 16) tlen = 16;
            msg = {b.block_high, b.block_low};
            if (!subkeys_ok)
            begin
                expand();
                k1 = dbl(encrypt('0));
                k2 = dbl(k1);
                subkeys_ok = 1'b1;
            end
            exp_tag = '0;
            exp_tag.tag_length = tlen[4:0];
            if ((!b.last_block && nbytes != 16) || (b.last_block && nbytes == 0 && in_message))
            begin
                chain = '0;
                in_message = 1'b0;
                exp_tag.status = 1'b1;
                pending_tags.push_back(exp_tag);
                errors_seen++;
                return;
            end
            if (!b.last_block)
            begin
                chain = encrypt(chain ^ msg);
                in_message = 1'b1;
                return;
            end
            if (nbytes == 16)
                chain = encrypt(chain ^ msg ^ k1);
            else
            begin
                for (int i = 0; i < 16; i++)
                    if (i == nbytes)
                        msg[127 - 8 * i -: 8] = PAD_BYTE;
                    else if (i > nbytes)
                        msg[127 - 8 * i -: 8] = 8'h00;
                chain = encrypt(chain ^ msg ^ k2);
            end
            res = chain;
            for (int i = tlen; i < 16; i++)
                res[127 - 8 * i -: 8] = 8'h00;
            {exp_tag.tag_high, exp_tag.tag_low} = res;
            pending_tags.push_back(exp_tag);
            chain = '0;
            in_message = 1'b0;
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %h, expected %h", what, got, want);
            mismatches++;
        endtask

        task check_tag(acm_out_t got);
            acm_out_t want;
            if (pending_tags.size() == 0)
            begin
                report_mismatch("unexpected tag transfer", got.tag_high, 64'h0);
                return;
            end
            want = pending_tags.pop_front();
            tags_checked++;
            if (got.tag_high !== want.tag_high)
                report_mismatch("tag_high", got.tag_high, want.tag_high);
            if (got.tag_low !== want.tag_low)
                report_mismatch("tag_low", got.tag_low, want.tag_low);
            if (got.tag_length !== want.tag_length)
                report_mismatch("tag_length", 64'(got.tag_length), 64'(want.tag_length));
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        blk_valid;
    logic        blk_stall;
    acm_in_t     blk;
    logic        tag_valid;
    logic        tag_stall;
    acm_out_t    tag;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_wdata;

    cmac_scoreboard sb;
    longint cycles;
    int     blocks_sent;
    bit     stall_quiet;

    aes_cmac_tag i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk       (blk),
        .tag_valid (tag_valid),
        .tag_stall (tag_stall),
        .tag       (tag),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d tags outstanding",
                     cycles, sb.pending_tags.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && tag_valid && !tag_stall)
            sb.check_tag(tag);

    // Receiver back-pressure: short bursts mostly, the odd long one, quiet spells
    int stall_left;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            tag_stall = 1'b1;
        end
        else if (!stall_quiet && $urandom_range(0, 99) < 30)
        begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 3);
            tag_stall = 1'b1;
        end
        else
            tag_stall = 1'b0;
    end

    function int pick_gap();
        if (stall_quiet)
            return 0;
        if ($urandom_range(0, 29) == 0)
            return $urandom_range(15, 50);
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Entered and left at a falling edge
    task send_block(logic [63:0] hi, logic [63:0] lo, int nbytes, bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            blk_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        blk.block_high  = hi;
        blk.block_low   = lo;
        blk.valid_bytes = nbytes[4:0];
        blk.last_block  = last;
        blk_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!blk_stall)
                break;
        end
        sb.note_block(blk);
        blocks_sent++;
        @(negedge clk);
    endtask

    task send_message(int nfull, int last_bytes);
        for (int i = 0; i < nfull; i++)
            send_block(rand64(), rand64(), 16, 1'b0);
        send_block(rand64(), rand64(), last_bytes, 1'b1);
    endtask

    task write_cfg(logic [2:0] idx, logic [63:0] val);
        cfg_addr  = idx;
        cfg_wdata = val;
        cfg_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the sender until every tag is back, then let the engine finish
    task drain();
        blk_valid = 1'b0;
        while (sb.pending_tags.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task random_traffic(int count);
        int start;
        int nfull;
        start = blocks_sent;
        while (blocks_sent - start < count)
        begin
            if ($urandom_range(0, 9) == 0)
                send_block(rand64(), rand64(), $urandom_range(0, 31), $urandom_range(0, 1));
            else
            begin
                nfull = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                send_message(nfull, $urandom_range(nfull == 0 ? 0 : 1, 16));
            end
        end
    endtask

    initial
    begin
        logic [63:0] kv [4];
        int tb_choice [6] = '{16, 1, 0, 31, 7, 16};
        int kl_choice [6] = '{0, 1, 2, 3, 0, 2};
        sb = new();
        blocks_sent = 0;
        stall_quiet = 1'b0;
        rst_n = 1'b0;
        blk_valid = 1'b0;
        blk = '0;
        cfg_valid = 1'b0;
        cfg_addr = CFG_KEY_A;
        cfg_wdata = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset key, empty message, extremes, padding, error cases
        send_block('0, '0, 0, 1'b1);
        send_block('1, '1, 16, 1'b1);
        send_block('0, '0, 16, 1'b1);
        send_block('1, '1, 15, 1'b1);
        send_block('1, '1, 1, 1'b1);
        send_block(rand64(), rand64(), 31, 1'b1);
        send_block(rand64(), rand64(), 17, 1'b0);
        send_block('1, '1, 16, 1'b0);
        send_block('0, '0, 16, 1'b0);
        send_block(rand64(), rand64(), 8, 1'b1);
        send_block(rand64(), rand64(), 16, 1'b0);
        send_block(rand64(), rand64(), 0, 1'b1);
        send_block(rand64(), rand64(), 16, 1'b0);
        send_block(rand64(), rand64(), 5, 1'b0);
        send_block(rand64(), rand64(), 0, 1'b0);
        send_block(rand64(), rand64(), 16, 1'b0);
        send_block(rand64(), rand64(), 16, 1'b0);
        send_block(rand64(), rand64(), 16, 1'b1);
        // open chain left hanging across a key change
        send_block(rand64(), rand64(), 16, 1'b0);
        drain();
        write_cfg(CFG_KEY_A, rand64());
        send_block(rand64(), rand64(), 3, 1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            for (int k = 0; k < 4; k++)
                kv[k] = (ph == 2) ? '1 : ((ph == 4) ? '0 : rand64());
            for (int k = 0; k < 4; k++)
                write_cfg(CFG_KEY_A + k[2:0], kv[k]);
            write_cfg(CFG_KEY_LEN, 64'(kl_choice[ph]));
            write_cfg(CFG_TAG_LEN, 64'(tb_choice[ph]));
            stall_quiet = (ph == 3);
            random_traffic(215);
            drain();
        end
        stall_quiet = 1'b0;

        $display("Covered %0d blocks in 6 key/tag settings plus directed cases;",
                 blocks_sent);
        $display("%0d tag transfers checked, %0d of them length errors",
                 sb.tags_checked, sb.errors_seen);
        if (sb.mismatches == 0 && sb.pending_tags.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
